// ===== hdl/pcdr_pkg.sv =====
`timescale 1ns / 1ps

package pcdr_pkg;

    // event codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_DOWN = 3'd0,
        CMD_UP   = 3'd1,
        CMD_MOVE = 3'd2,
        CMD_TICK = 3'd3,
        CMD_LOCK = 3'd4
    } cmd_t;

    // gesture codes carried on the output tuser
    typedef enum logic [1:0] {
        G_CLICK      = 2'd0,
        G_DRAG_START = 2'd1,
        G_DRAG       = 2'd2,
        G_DRAG_END   = 2'd3
    } gesture_t;

    // configuration register indexes
    localparam logic CFG_DRAG_THRESHOLD = 1'b0;
    localparam logic CFG_AUTO_DRAG_TIME = 1'b1;

    localparam int THRESH_W = 32;
    localparam int TIME_W   = 16;
    localparam int POS_W    = 16;

    localparam logic [THRESH_W-1:0] DRAG_THRESHOLD_RST = 32'h0000_0019;
    localparam logic [TIME_W-1:0]   AUTO_DRAG_TIME_RST = 16'd1000;
    localparam logic [TIME_W-1:0]   HOLD_TICKS_MAX     = 16'hFFFF;

endpackage

// ===== hdl/pointer_click_drag_recognizer_top.sv =====
`timescale 1ns / 1ps

// Pointer click and drag recognizer. Every input beat (button down, button
// up, move, millisecond tick, drag-lock toggle) produces exactly one output
// beat; emitted = 1 marks a real gesture (click, drag start, drag, drag end),
// otherwise gesture and position are zero. A held move starts a drag once the
// squared distance from the press exceeds drag_threshold; a hold lasting
// auto_drag_time ticks starts one too. The block takes one beat per cycle
// unless a held result is not taken (s_tready then falls); the squared-distance
// compare and all flag updates sit between the input handshake and the output
// register, and the state is updated in the cycle the beat is accepted, so the
// next beat sees it at once. The output register lets a new beat enter while
// the previous result is being taken. Configuration writes are applied at once
// and should only be made while no beat is in flight.
module pointer_click_drag_recognizer_top (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,

    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pos_x[15:0], pos_y[31:16], left_held[32], zero pad
    input  logic [2:0]  s_tuser,   // command[2:0]

    // gesture results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // emitted[0], out_x[16:1], out_y[32:17], zero pad
    output logic [1:0]  m_tuser    // gesture[1:0]
);

    localparam int PW = pcdr_pkg::POS_W;

    // configuration
    logic [pcdr_pkg::THRESH_W-1:0] drag_threshold_reg;
    logic [pcdr_pkg::TIME_W-1:0]   auto_drag_time_reg;

    // gesture state
    logic signed [PW-1:0] press_x_reg, press_x_next;
    logic signed [PW-1:0] press_y_reg, press_y_next;
    logic button_pressed_reg, button_pressed_next;
    logic drag_active_reg, drag_active_next;
    logic drag_lock_reg, drag_lock_next;
    logic hold_armed_reg, hold_armed_next;
    logic [pcdr_pkg::TIME_W-1:0] hold_ticks_reg, hold_ticks_next;

    // output register
    logic                 m_valid_reg;
    logic                 emitted_reg, emitted_next;
    pcdr_pkg::gesture_t   gesture_reg, gesture_next;
    logic signed [PW-1:0] out_x_reg, out_x_next;
    logic signed [PW-1:0] out_y_reg, out_y_next;

    // unpacked input beat
    pcdr_pkg::cmd_t       cmd;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic                 left_held;
    logic                 in_beat;

    // distance path
    logic signed [PW:0]     dx;
    logic signed [PW:0]     dy;
    logic [2*PW-1:0]        dx_sq;
    logic [2*PW-1:0]        dy_sq;
    logic [2*PW:0]          dist_sq;
    logic                   far_enough;
    logic                   held_eff;
    logic [pcdr_pkg::TIME_W-1:0] ticks_inc;

    assign cmd       = pcdr_pkg::cmd_t'(s_tuser);
    assign pos_x     = s_tdata[PW-1:0];
    assign pos_y     = s_tdata[2*PW-1:PW];
    assign left_held = s_tdata[2*PW];

    assign s_tready = !m_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    // squares of 17-bit differences are non-negative and fit in 32 bits
    assign dx    = {pos_x[PW-1], pos_x} - {press_x_reg[PW-1], press_x_reg};
    assign dy    = {pos_y[PW-1], pos_y} - {press_y_reg[PW-1], press_y_reg};
    assign dx_sq = (2*PW)'(dx * dx);
    assign dy_sq = (2*PW)'(dy * dy);
    assign dist_sq    = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign far_enough = dist_sq > {1'b0, drag_threshold_reg};

    assign held_eff  = drag_lock_reg || left_held;
    assign ticks_inc = (hold_ticks_reg == pcdr_pkg::HOLD_TICKS_MAX) ?
                       hold_ticks_reg : hold_ticks_reg + 1'b1;

    always_comb begin
        press_x_next        = press_x_reg;
        press_y_next        = press_y_reg;
        button_pressed_next = button_pressed_reg;
        drag_active_next    = drag_active_reg;
        drag_lock_next      = drag_lock_reg;
        hold_armed_next     = hold_armed_reg;
        hold_ticks_next     = hold_ticks_reg;
        emitted_next        = 1'b0;
        gesture_next        = pcdr_pkg::G_CLICK;
        out_x_next          = '0;
        out_y_next          = '0;

        case (cmd)
            pcdr_pkg::CMD_DOWN: begin
                if (drag_lock_reg) begin
                    // a press in drag lock only drops the lock
                    drag_lock_next = 1'b0;
                end else begin
                    press_x_next        = pos_x;
                    press_y_next        = pos_y;
                    drag_active_next    = 1'b0;
                    button_pressed_next = 1'b1;
                    hold_armed_next     = 1'b1;
                    hold_ticks_next     = '0;
                end
            end
            pcdr_pkg::CMD_UP: begin
                hold_armed_next     = 1'b0;
                drag_active_next    = 1'b0;
                button_pressed_next = 1'b0;
                if (drag_active_reg) begin
                    emitted_next = 1'b1;
                    gesture_next = pcdr_pkg::G_DRAG_END;
                    out_x_next   = pos_x;
                    out_y_next   = pos_y;
                end else if (button_pressed_reg) begin
                    emitted_next = 1'b1;
                    gesture_next = pcdr_pkg::G_CLICK;
                    out_x_next   = press_x_reg;
                    out_y_next   = press_y_reg;
                end
            end
            pcdr_pkg::CMD_MOVE: begin
                if ((drag_lock_reg || button_pressed_reg) && held_eff) begin
                    if (drag_active_reg) begin
                        emitted_next = 1'b1;
                        gesture_next = pcdr_pkg::G_DRAG;
                        out_x_next   = pos_x;
                        out_y_next   = pos_y;
                    end else if (drag_lock_reg) begin
                        // in lock the drag starts right at the pointer
                        press_x_next     = pos_x;
                        press_y_next     = pos_y;
                        hold_armed_next  = 1'b0;
                        drag_active_next = 1'b1;
                        emitted_next     = 1'b1;
                        gesture_next     = pcdr_pkg::G_DRAG_START;
                        out_x_next       = pos_x;
                        out_y_next       = pos_y;
                    end else if (far_enough) begin
                        hold_armed_next  = 1'b0;
                        drag_active_next = 1'b1;
                        emitted_next     = 1'b1;
                        gesture_next     = pcdr_pkg::G_DRAG_START;
                        out_x_next       = press_x_reg;
                        out_y_next       = press_y_reg;
                    end
                end
            end
            pcdr_pkg::CMD_TICK: begin
                if (hold_armed_reg) begin
                    hold_ticks_next = ticks_inc;
                    if (ticks_inc >= auto_drag_time_reg) begin
                        hold_armed_next = 1'b0;
                        if (button_pressed_reg) begin
                            drag_active_next = 1'b1;
                            emitted_next     = 1'b1;
                            gesture_next     = pcdr_pkg::G_DRAG_START;
                            out_x_next       = press_x_reg;
                            out_y_next       = press_y_reg;
                        end else begin
                            drag_active_next = 1'b0;
                        end
                    end
                end
            end
            pcdr_pkg::CMD_LOCK: begin
                if (drag_lock_reg) begin
                    drag_active_next = 1'b0;
                    emitted_next     = 1'b1;
                    gesture_next     = pcdr_pkg::G_DRAG_END;
                    out_x_next       = pos_x;
                    out_y_next       = pos_y;
                end
                drag_lock_next = !drag_lock_reg;
            end
            default: begin
                // unused codes leave the state alone and report nothing
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drag_threshold_reg <= pcdr_pkg::DRAG_THRESHOLD_RST;
            auto_drag_time_reg <= pcdr_pkg::AUTO_DRAG_TIME_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pcdr_pkg::CFG_DRAG_THRESHOLD: drag_threshold_reg <= cfg_wdata;
                pcdr_pkg::CFG_AUTO_DRAG_TIME:
                    auto_drag_time_reg <= cfg_wdata[pcdr_pkg::TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // gesture state, updated once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_x_reg        <= '0;
            press_y_reg        <= '0;
            button_pressed_reg <= 1'b0;
            drag_active_reg    <= 1'b0;
            drag_lock_reg      <= 1'b0;
            hold_armed_reg     <= 1'b0;
            hold_ticks_reg     <= '0;
        end else if (in_beat) begin
            press_x_reg        <= press_x_next;
            press_y_reg        <= press_y_next;
            button_pressed_reg <= button_pressed_next;
            drag_active_reg    <= drag_active_next;
            drag_lock_reg      <= drag_lock_next;
            hold_armed_reg     <= hold_armed_next;
            hold_ticks_reg     <= hold_ticks_next;
        end
    end

    // output register: valid is control, payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            emitted_reg <= emitted_next;
            gesture_reg <= gesture_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_y_reg, out_x_reg, emitted_reg};
    assign m_tuser  = gesture_reg;

endmodule

// ===== tb/tb_pointer_click_drag_recognizer_top.sv =====
`timescale 1ns / 1ps

module tb_pointer_click_drag_recognizer_top;

    // input codes above the lock toggle carry no meaning and must be ignored
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    // one expected result beat, as the recognizer should report it
    typedef struct packed {
        logic               emitted;
        pcdr_pkg::gesture_t gesture;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } gesture_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // pos_x[15:0], pos_y[31:16], left_held[32], zero pad
    logic [2:0]  s_tuser;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // emitted[0], out_x[16:1], out_y[32:17], zero pad
    logic [1:0]  m_tuser;   // gesture[1:0]

    // shadow copy of the recognizer: configuration and gesture state
    logic [pcdr_pkg::THRESH_W-1:0]     drag_thr;
    logic [pcdr_pkg::TIME_W-1:0]       hold_limit;
    logic signed [pcdr_pkg::POS_W-1:0] anchor_x;
    logic signed [pcdr_pkg::POS_W-1:0] anchor_y;
    logic                              btn_down;
    logic                              dragging;
    logic                              lock_on;
    logic                              timer_running;
    logic [pcdr_pkg::TIME_W-1:0]       tick_count;

    // gestures predicted but not yet seen on the result side, oldest first
    gesture_beat_t pending_gestures[$];
    int            mismatch_count;
    int            events_sent;

    // pacing knobs: sender bursts with gaps, receiver stall pattern
    bit sender_gaps;
    bit receiver_stalls;
    int burst_left;
    int ready_left = 0;

    pointer_click_drag_recognizer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // gesture prediction: updates the shadow state, returns the result beat
    // ------------------------------------------------------------------
    function automatic gesture_beat_t predict_gesture(logic [2:0] cmd,
            logic signed [15:0] x, logic signed [15:0] y, logic held);
        gesture_beat_t r;
        longint        dx;
        longint        dy;
        logic [63:0]   dist_sq;
        r = '0;
        case (cmd)
            pcdr_pkg::CMD_DOWN: begin
                // a press while locked only drops the lock
                if (lock_on) begin
                    lock_on = 1'b0;
                end else begin
                    anchor_x      = x;
                    anchor_y      = y;
                    dragging      = 1'b0;
                    btn_down      = 1'b1;
                    timer_running = 1'b1;
                    tick_count    = '0;
                end
            end
            pcdr_pkg::CMD_UP: begin
                timer_running = 1'b0;
                if (dragging) begin
                    r = '{1'b1, pcdr_pkg::G_DRAG_END, x, y};
                end else if (btn_down) begin
                    r = '{1'b1, pcdr_pkg::G_CLICK, anchor_x, anchor_y};
                end
                dragging = 1'b0;
                btn_down = 1'b0;
            end
            pcdr_pkg::CMD_MOVE: begin
                // in lock mode every move counts as held
                if ((lock_on || btn_down) && (held || lock_on)) begin
                    if (!dragging) begin
                        if (lock_on) begin
                            anchor_x = x;
                            anchor_y = y;
                        end
                        // exact squared distance, compared unsigned
                        dx      = longint'(x) - longint'(anchor_x);
                        dy      = longint'(y) - longint'(anchor_y);
                        dist_sq = dx * dx + dy * dy;
                        if (lock_on || dist_sq > {32'd0, drag_thr}) begin
                            timer_running = 1'b0;
                            dragging      = 1'b1;
                            r = '{1'b1, pcdr_pkg::G_DRAG_START, anchor_x, anchor_y};
                        end
                    end else begin
                        r = '{1'b1, pcdr_pkg::G_DRAG, x, y};
                    end
                end
            end
            pcdr_pkg::CMD_TICK: begin
                if (timer_running) begin
                    if (tick_count != pcdr_pkg::HOLD_TICKS_MAX) begin
                        tick_count = tick_count + 16'd1;
                    end
                    if (tick_count >= hold_limit) begin
                        timer_running = 1'b0;
                        if (btn_down) begin
                            dragging = 1'b1;
                            r = '{1'b1, pcdr_pkg::G_DRAG_START, anchor_x, anchor_y};
                        end else begin
                            dragging = 1'b0;
                        end
                    end
                end
            end
            pcdr_pkg::CMD_LOCK: begin
                // leaving lock always reports a drag end at the pointer
                if (lock_on) begin
                    dragging = 1'b0;
                    r = '{1'b1, pcdr_pkg::G_DRAG_END, x, y};
                end
                lock_on = !lock_on;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_pos();
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // sender: one input beat, driven at the falling edge, held until taken
    // ------------------------------------------------------------------
    task automatic send_event(logic [2:0] cmd, logic [15:0] x, logic [15:0] y,
            logic held);
        int gap;
        @(negedge aclk);
        // the beat will be taken before any later one, so predict it now
        pending_gestures.insert(pending_gestures.size(), predict_gesture(cmd, x, y, held));
        s_tdata  <= {7'd0, held, y, x};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
        // burst bookkeeping: valid stays high inside a burst
        if (burst_left > 0) begin
            burst_left--;
        end else if (sender_gaps) begin
            burst_left = $urandom_range(0, 15);
            gap        = $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // stop sending and wait until every predicted gesture has come back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_gestures.size() != 0) @(posedge aclk);
    endtask

    // register write, only with nothing in flight
    task automatic write_register(logic idx, logic [31:0] value);
        wait_results_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == pcdr_pkg::CFG_DRAG_THRESHOLD) begin
            drag_thr = value;
        end else begin
            hold_limit = value[pcdr_pkg::TIME_W-1:0];
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: ready pattern with stall stretches and free-running stretches
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(0, 4);
            end else begin
                m_tready   <= 1'b1;
                ready_left = receiver_stalls ? $urandom_range(0, 9) : 0;
            end
        end else begin
            ready_left--;
        end
    end

    // result checker: every accepted result beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        gesture_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_gestures.size() == 0) begin
                $error("result beat with no gesture pending");
                mismatch_count++;
            end else begin
                want = pending_gestures.pop_front();
                if (m_tdata[0] !== want.emitted) begin
                    $error("emitted mismatch: expected %0d, got %0d",
                           want.emitted, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.gesture) begin
                    $error("gesture mismatch: expected %0d, got %0d",
                           want.gesture, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[16:1] !== want.x) begin
                    $error("out_x mismatch: expected %0d, got %0d",
                           $signed(want.x), $signed(m_tdata[16:1]));
                    mismatch_count++;
                end
                if (m_tdata[32:17] !== want.y) begin
                    $error("out_y mismatch: expected %0d, got %0d",
                           $signed(want.y), $signed(m_tdata[32:17]));
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // click, threshold boundary, drag, drag end, ignored codes; reset settings
    task automatic test_click_and_drag();
        send_event(pcdr_pkg::CMD_DOWN, 16'h8000, 16'h7FFF, 1'b0);
        send_event(pcdr_pkg::CMD_UP, 16'sd5, 16'sd5, 1'b1);         // click at press
        send_event(pcdr_pkg::CMD_UP, 16'sd5, 16'sd5, 1'b0);         // nothing pressed
        send_event(pcdr_pkg::CMD_DOWN, 16'sd0, 16'sd0, 1'b1);
        send_event(pcdr_pkg::CMD_MOVE, 16'sd3, 16'sd4, 1'b1);       // exactly 25: no drag
        send_event(pcdr_pkg::CMD_MOVE, 16'sd100, 16'sd100, 1'b0);   // not held
        send_event(pcdr_pkg::CMD_MOVE, 16'sd5, 16'sd1, 1'b1);       // 26: drag start
        send_event(pcdr_pkg::CMD_MOVE, 16'h7FFF, 16'h8000, 1'b1);   // drag
        send_event(pcdr_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0);       // timer already off
        send_event(pcdr_pkg::CMD_UP, 16'sd7, -16'sd7, 1'b0);        // drag end at pointer
        send_event(pcdr_pkg::CMD_MOVE, 16'sd40, 16'sd40, 1'b1);     // held move, no press
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
            send_event(3'(c), 16'hFFFF, 16'hFFFF, 1'b1);
        end
    endtask

    // lock mode: first move drags from the pointer, press drops the lock
    task automatic test_drag_lock();
        send_event(pcdr_pkg::CMD_LOCK, 16'sd1, 16'sd1, 1'b0);
        send_event(pcdr_pkg::CMD_MOVE, -16'sd100, 16'sd200, 1'b0);  // drag start here
        send_event(pcdr_pkg::CMD_MOVE, -16'sd90, 16'sd210, 1'b0);   // drag
        send_event(pcdr_pkg::CMD_LOCK, 16'sd3, 16'sd4, 1'b1);       // drag end
        send_event(pcdr_pkg::CMD_LOCK, 16'sd0, 16'sd0, 1'b0);
        send_event(pcdr_pkg::CMD_DOWN, 16'sd9, 16'sd9, 1'b0);       // only drops the lock
        send_event(pcdr_pkg::CMD_MOVE, 16'sd50, 16'sd50, 1'b1);     // nothing pressed
        send_event(pcdr_pkg::CMD_UP, 16'sd0, 16'sd0, 1'b0);
        send_event(pcdr_pkg::CMD_LOCK, 16'sd2, 16'sd2, 1'b0);
        send_event(pcdr_pkg::CMD_LOCK, -16'sd2, -16'sd2, 1'b0);     // drag end while idle
    endtask

    // register extremes: zero threshold and one-tick hold, then the maxima
    task automatic test_config_extremes();
        write_register(pcdr_pkg::CFG_DRAG_THRESHOLD, 32'd0);
        write_register(pcdr_pkg::CFG_AUTO_DRAG_TIME, 32'd1);
        send_event(pcdr_pkg::CMD_DOWN, 16'sd10, 16'sd10, 1'b0);
        send_event(pcdr_pkg::CMD_MOVE, 16'sd10, 16'sd10, 1'b1);     // zero distance
        send_event(pcdr_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0);       // hold expires
        send_event(pcdr_pkg::CMD_MOVE, 16'sd12, 16'sd10, 1'b1);
        send_event(pcdr_pkg::CMD_UP, 16'sd12, 16'sd10, 1'b0);
        send_event(pcdr_pkg::CMD_DOWN, 16'sd10, 16'sd10, 1'b0);
        send_event(pcdr_pkg::CMD_MOVE, 16'sd11, 16'sd10, 1'b1);     // one pixel drags
        send_event(pcdr_pkg::CMD_UP, 16'sd11, 16'sd10, 1'b0);

        write_register(pcdr_pkg::CFG_DRAG_THRESHOLD, 32'hFFFF_FFFF);
        write_register(pcdr_pkg::CFG_AUTO_DRAG_TIME, 32'd65535);
        // just under and just over the largest threshold
        send_event(pcdr_pkg::CMD_DOWN, 16'h8000, 16'sd0, 1'b0);
        send_event(pcdr_pkg::CMD_MOVE, 16'h7FFF, 16'sd0, 1'b1);
        send_event(pcdr_pkg::CMD_MOVE, 16'h7FFF, 16'sd362, 1'b1);
        send_event(pcdr_pkg::CMD_MOVE, 16'h7FFF, 16'sd363, 1'b1);
        send_event(pcdr_pkg::CMD_UP, 16'sd0, 16'sd0, 1'b0);
        // corner to corner: the squared distance needs more than 32 bits
        send_event(pcdr_pkg::CMD_DOWN, 16'h8000, 16'h8000, 1'b0);
        send_event(pcdr_pkg::CMD_MOVE, 16'h7FFF, 16'h7FFF, 1'b1);
        send_event(pcdr_pkg::CMD_UP, 16'h7FFF, 16'h7FFF, 1'b0);
    endtask

    // a hold that runs out and keeps ticking, then a short one after release
    task automatic test_long_hold();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        write_register(pcdr_pkg::CFG_AUTO_DRAG_TIME, 32'd40);
        send_event(pcdr_pkg::CMD_DOWN, rand_pos(), rand_pos(), 1'b0);
        for (int i = 0; i < 44; i++) begin
            send_event(pcdr_pkg::CMD_TICK, rand_pos(), rand_pos(), 1'(i));
        end
        send_event(pcdr_pkg::CMD_UP, rand_pos(), rand_pos(), 1'b0);
        write_register(pcdr_pkg::CFG_AUTO_DRAG_TIME, 32'd2);
        send_event(pcdr_pkg::CMD_DOWN, 16'sd1, 16'sd2, 1'b0);
        send_event(pcdr_pkg::CMD_UP, 16'sd3, 16'sd4, 1'b0);
        send_event(pcdr_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0);       // disarmed by release
        send_event(pcdr_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0);
    endtask

    // press, a few moves and ticks near the press point, usually a release
    task automatic play_gesture();
        logic [15:0] bx;
        logic [15:0] by;
        int          reach;
        bx    = rand_pos();
        by    = rand_pos();
        reach = ($urandom_range(0, 2) == 0) ? 40 : (($urandom_range(0, 1) != 0) ? 12 : 3);
        send_event(pcdr_pkg::CMD_DOWN, bx, by, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_event(pcdr_pkg::CMD_TICK, rand_pos(), rand_pos(),
                                   1'($urandom_range(0, 1)));
                    end
                end
                2: send_event(pcdr_pkg::CMD_MOVE, rand_pos(), rand_pos(), 1'b0);
                default: begin
                    send_event(pcdr_pkg::CMD_MOVE,
                               bx + 16'(int'($urandom_range(0, 2 * reach)) - reach),
                               by + 16'(int'($urandom_range(0, 2 * reach)) - reach),
                               1'b1);
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) begin
            send_event(pcdr_pkg::CMD_UP, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        end
    endtask

    // lock on, moves (sometimes a press that drops the lock), mostly lock off
    task automatic play_locked_drag();
        send_event(pcdr_pkg::CMD_LOCK, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 5) == 0) begin
                send_event(pcdr_pkg::CMD_DOWN, rand_pos(), rand_pos(),
                           1'($urandom_range(0, 1)));
            end else begin
                send_event(pcdr_pkg::CMD_MOVE, rand_pos(), rand_pos(),
                           1'($urandom_range(0, 1)));
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            send_event(pcdr_pkg::CMD_LOCK, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
        end
    endtask

    // mostly well-formed gestures, some lock drags, the rest raw noise
    task automatic test_random_traffic(logic [31:0] thr, logic [31:0] hold, int n_events,
            bit idling);
        int first;
        write_register(pcdr_pkg::CFG_DRAG_THRESHOLD, thr);
        write_register(pcdr_pkg::CFG_AUTO_DRAG_TIME, hold);
        sender_gaps     = idling;
        receiver_stalls = idling;
        first           = events_sent;
        while (events_sent - first < n_events) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: play_gesture();
                6: play_locked_drag();
                default: begin
                    send_event(3'($urandom_range(0, 7)), rand_pos(), rand_pos(),
                               1'($urandom_range(0, 1)));
                end
            endcase
            // now and then hold off until the result side has caught up
            if ($urandom_range(0, 39) == 0) begin
                wait_results_drained();
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = 1'b0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        mismatch_count  = 0;
        events_sent     = 0;
        burst_left      = 0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;

        // shadow state as after reset
        drag_thr      = pcdr_pkg::DRAG_THRESHOLD_RST;
        hold_limit    = pcdr_pkg::AUTO_DRAG_TIME_RST;
        anchor_x      = '0;
        anchor_y      = '0;
        btn_down      = 1'b0;
        dragging      = 1'b0;
        lock_on       = 1'b0;
        timer_running = 1'b0;
        tick_count    = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part runs with free-flowing handshakes, then with stalls
        test_click_and_drag();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        test_drag_lock();
        test_config_extremes();
        test_long_hold();

        test_random_traffic(32'd25, 32'd8, 300, 1'b1);
        test_random_traffic(32'($urandom_range(0, 400)), 32'($urandom_range(1, 12)), 300,
                            1'b0);
        test_random_traffic($urandom, 32'($urandom_range(1, 65535)), 200, 1'b1);
        test_random_traffic(32'd0, 32'd1, 300, 1'b1);

        // let the last result beats through, then a short settle
        wait_results_drained();
        repeat (4) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
